// ----- sv/gntt_pkg.sv -----
// gntt_pkg: shared types, constants and register codes of the gated nearest-target tracker
// depends on nothing; imported by every module of the tracker
package gntt_pkg;

  // coordinate width that the distance math uses (the input fields are 16 bits wide)
  localparam int CoordBits = 16;
  localparam int CoordW    = (CoordBits < 16) ? CoordBits : 16;
  localparam int SqW       = 2 * CoordW;
  localparam int DistW     = SqW + 1;
  localparam int GateSqW   = 32;
  localparam int CmpW      = (DistW > GateSqW + 1) ? DistW : GateSqW + 1;

  // command queue between front and back
  localparam int CmdDepth = 4;
  localparam int CmdPtrW  = $clog2(CmdDepth);
  localparam int CmdCntW  = $clog2(CmdDepth + 1);

  // result buffer at the back end
  localparam int ResDepth = 2;
  localparam int ResPtrW  = $clog2(ResDepth);
  localparam int ResCntW  = $clog2(ResDepth + 1);

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgMinScore   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMissLimit  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGateRadius = 2'd2;

  localparam logic [9:0]         MinScoreRst   = 10'd0;
  localparam logic [7:0]         MissLimitRst  = 8'd5;
  localparam logic [15:0]        GateRadiusRst = 16'd1600;
  localparam logic [GateSqW-1:0] GateSqRst     =
    GateSqW'(GateSqW'(GateRadiusRst) * GateSqW'(GateRadiusRst));

  // request codes on the input channel
  typedef enum logic [1:0] {
    ReqDetect   = 2'd0,
    ReqFrameEnd = 2'd1,
    ReqDropLock = 2'd2
  } req_e;

  // commands after classification
  typedef enum logic [1:0] {
    CmdDetect   = 2'd0,
    CmdFrameEnd = 2'd1,
    CmdDropLock = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [9:0]  score;
  } in_item_t;

  typedef struct packed {
    logic        has_target;
    logic [15:0] target_x;
    logic [15:0] target_y;
    logic [15:0] target_width;
    logic [15:0] target_height;
    logic [9:0]  target_score;
  } out_item_t;

  typedef struct packed {
    logic [9:0]         min_score;
    logic [7:0]         miss_limit;
    logic [GateSqW-1:0] gate_sq;
  } cfg_t;

  typedef struct packed {
    cmd_e              kind;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [15:0]       w;
    logic [15:0]       h;
    logic [9:0]        score;
  } cmd_t;

endpackage

// ----- sv/gntt_front.sv -----
// gntt_front: classifies incoming transactions and filters low-score detections
// depends on gntt_pkg
module gntt_front import gntt_pkg::*; (
  input  logic     accept_i,
  input  in_item_t in_item_i,
  input  cfg_t     cfg_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic keep;

  // decode request, mask coordinates, drop what has no effect
  always_comb begin
    cmd_o.kind  = CmdDetect;
    cmd_o.x     = in_item_i.center_x[CoordW-1:0];
    cmd_o.y     = in_item_i.center_y[CoordW-1:0];
    cmd_o.w     = in_item_i.box_width;
    cmd_o.h     = in_item_i.box_height;
    cmd_o.score = in_item_i.score;
    keep        = 1'b0;
    case (req_e'(in_item_i.req_type))
      ReqDetect: begin
        keep = (in_item_i.score >= cfg_i.min_score);
      end
      ReqFrameEnd: begin
        cmd_o.kind = CmdFrameEnd;
        keep       = 1'b1;
      end
      ReqDropLock: begin
        cmd_o.kind = CmdDropLock;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_push_o = accept_i & keep;

endmodule

// ----- sv/gntt_cmd_fifo.sv -----
// gntt_cmd_fifo: short command queue that decouples the front from the back
// depends on gntt_pkg
module gntt_cmd_fifo import gntt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CmdCntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CmdCntW'(CmdDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/gntt_back.sv -----
// gntt_back: squared-distance stage, candidate search, lock update and result buffer
// depends on gntt_pkg
module gntt_back import gntt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      res_pop_i,
  output logic      res_empty_o,
  output out_item_t res_o
);

  // lock and search state
  logic              lock_valid_q, lock_valid_d;
  cmd_t              lock_q, lock_d;
  logic [8:0]        miss_q, miss_d;
  logic [8:0]        miss_inc;
  logic              near_found_q, near_found_d;
  logic [DistW-1:0]  near_dist_q, near_dist_d;
  cmd_t              near_q, near_d;
  logic              top_found_q, top_found_d;
  cmd_t              top_q, top_d;

  // distance stage
  logic              s2_valid_q, s2_valid_d;
  cmd_t              s2_cmd_q;
  logic [SqW-1:0]    s2_xsq_q, s2_ysq_q;
  logic [CoordW-1:0] dx, dy;
  logic [SqW-1:0]    xsq, ysq;
  logic              s2_ctrl, s2_fire, load;
  logic [DistW-1:0]  d2;
  logic              gate_ok;

  // result buffer
  out_item_t          res_mem_q [ResDepth];
  logic [ResPtrW-1:0] res_wr_q, res_rd_q;
  logic [ResCntW-1:0] res_cnt_q;
  logic               res_room, res_push, res_pop;
  out_item_t          res_new;

  // squared distance of the queue head to the committed lock centre
  assign dx  = (cmd_i.x >= lock_q.x) ? cmd_i.x - lock_q.x : lock_q.x - cmd_i.x;
  assign dy  = (cmd_i.y >= lock_q.y) ? cmd_i.y - lock_q.y : lock_q.y - cmd_i.y;
  assign xsq = SqW'(dx) * SqW'(dx);
  assign ysq = SqW'(dy) * SqW'(dy);

  // a frame end or drop in the stage changes the lock: hold the next load until it has left the stage
  assign s2_ctrl    = s2_valid_q && (s2_cmd_q.kind != CmdDetect);
  assign res_room   = (res_cnt_q != ResCntW'(ResDepth));
  assign s2_fire    = s2_valid_q && ((s2_cmd_q.kind != CmdFrameEnd) || res_room);
  assign load       = cmd_valid_i && !s2_ctrl && (!s2_valid_q || s2_fire);
  assign cmd_pop_o  = load;
  assign s2_valid_d = load || (s2_valid_q && !s2_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s2_cmd_q <= cmd_i;
      s2_xsq_q <= xsq;
      s2_ysq_q <= ysq;
    end
  end

  // gate check on the registered squares
  assign d2      = DistW'(s2_xsq_q) + DistW'(s2_ysq_q);
  assign gate_ok = (CmpW'(d2) <= CmpW'(cfg_i.gate_sq));
  assign miss_inc = miss_q + 1'b1;

  // commit of the staged transaction
  always_comb begin
    lock_valid_d = lock_valid_q;
    lock_d       = lock_q;
    miss_d       = miss_q;
    near_found_d = near_found_q;
    near_dist_d  = near_dist_q;
    near_d       = near_q;
    top_found_d  = top_found_q;
    top_d        = top_q;
    res_push     = 1'b0;
    if (s2_fire) begin
      case (s2_cmd_q.kind)
        CmdDetect: begin
          if (lock_valid_q && gate_ok && (!near_found_q || (d2 < near_dist_q))) begin
            near_found_d = 1'b1;
            near_dist_d  = d2;
            near_d       = s2_cmd_q;
          end
          if (!top_found_q || (s2_cmd_q.score > top_q.score)) begin
            top_found_d = 1'b1;
            top_d       = s2_cmd_q;
          end
        end
        CmdFrameEnd: begin
          if (!top_found_q) begin
            if (lock_valid_q) begin
              if (miss_inc > {1'b0, cfg_i.miss_limit}) begin
                lock_valid_d = 1'b0;
                miss_d       = '0;
              end else begin
                miss_d = miss_inc;
              end
            end
          end else if (lock_valid_q && near_found_q) begin
            lock_valid_d = 1'b1;
            lock_d       = near_q;
            miss_d       = '0;
          end else begin
            lock_valid_d = 1'b1;
            lock_d       = top_q;
            miss_d       = '0;
          end
          near_found_d = 1'b0;
          top_found_d  = 1'b0;
          res_push     = 1'b1;
        end
        CmdDropLock: begin
          lock_valid_d = 1'b0;
          miss_d       = '0;
          near_found_d = 1'b0;
        end
        default: begin
          lock_valid_d = lock_valid_q;
        end
      endcase
    end
  end

  // result of a frame end: the lock as it stands after the update
  always_comb begin
    res_new               = '0;
    res_new.has_target    = lock_valid_d;
    if (lock_valid_d) begin
      res_new.target_x      = 16'(lock_d.x);
      res_new.target_y      = 16'(lock_d.y);
      res_new.target_width  = lock_d.w;
      res_new.target_height = lock_d.h;
      res_new.target_score  = lock_d.score;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_valid_q <= 1'b0;
      lock_q       <= '0;
      miss_q       <= '0;
      near_found_q <= 1'b0;
      top_found_q  <= 1'b0;
    end else begin
      lock_valid_q <= lock_valid_d;
      lock_q       <= lock_d;
      miss_q       <= miss_d;
      near_found_q <= near_found_d;
      top_found_q  <= top_found_d;
    end
  end

  // candidate payload, qualified by the found flags
  always_ff @(posedge clk_i) begin
    near_dist_q <= near_dist_d;
    near_q      <= near_d;
    top_q       <= top_d;
  end

  // two-entry result buffer
  assign res_pop     = res_pop_i && (res_cnt_q != '0);
  assign res_empty_o = (res_cnt_q == '0);
  assign res_o       = res_mem_q[res_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (res_push) begin
        res_wr_q <= (res_wr_q == ResPtrW'(ResDepth - 1)) ? '0 : res_wr_q + 1'b1;
      end
      if (res_pop) begin
        res_rd_q <= (res_rd_q == ResPtrW'(ResDepth - 1)) ? '0 : res_rd_q + 1'b1;
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + 1'b1;
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_new;
    end
  end

endmodule

// ----- sv/gated_nearest_target_tracker.sv -----
// gated_nearest_target_tracker: top level with configuration registers, front, queue and back
// depends on gntt_pkg, gntt_front, gntt_cmd_fifo, gntt_back
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+--------------------------
//   input    | push / full                   | in_item_i  (in_item_t)
//   result   | pop / empty                   | out_item_o (out_item_t)
//   config   | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// one detection per cycle sustained unless a frame end stalls on a full result buffer;
// a frame end or drop lock holds back the next item until it leaves the distance stage,
// since the next squared distance needs the new lock. on an idle block a frame end is
// queued, staged and written to the result buffer before empty falls; then it can be popped.
// full rises when the four-entry command queue fills; the back stalls a frame end
// while the two-entry result buffer is full. config is accepted every cycle.
// reset clears the lock and both searches and loads the register defaults.
module gated_nearest_target_tracker import gntt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_item_i,
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [9:0]         min_score_q;
  logic [7:0]         miss_limit_q;
  logic [15:0]        gate_radius_q;
  logic [GateSqW-1:0] gate_sq_q;
  cfg_t               cfg;

  logic accept;
  logic cmd_push, cmd_full, cmd_pop, cmd_valid;
  cmd_t cmd_in, cmd_out;

  assign cfg_ready_o = 1'b1;

  // configuration registers; the gate square is registered from the registered radius
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_score_q   <= MinScoreRst;
      miss_limit_q  <= MissLimitRst;
      gate_radius_q <= GateRadiusRst;
      gate_sq_q     <= GateSqRst;
    end else begin
      gate_sq_q <= GateSqW'(GateSqW'(gate_radius_q) * GateSqW'(gate_radius_q));
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgMinScore:   min_score_q   <= cfg_data_i[9:0];
          CfgMissLimit:  miss_limit_q  <= cfg_data_i[7:0];
          CfgGateRadius: gate_radius_q <= cfg_data_i;
          default:       min_score_q   <= min_score_q;
        endcase
      end
    end
  end

  assign cfg.min_score  = min_score_q;
  assign cfg.miss_limit = miss_limit_q;
  assign cfg.gate_sq    = gate_sq_q;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // front: classify and filter
  gntt_front u_front (
    .accept_i   (accept),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // queue between front and back
  gntt_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  // back: distance, search, lock and results
  gntt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (out_item_o)
  );

`ifndef SYNTHESIS
  // the front never writes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("command pushed into full queue");

  // the back only takes commands that are there
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // a result without a target carries all-zero fields
  a_no_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.has_target) |->
      (out_item_o.target_x == '0) && (out_item_o.target_y == '0) &&
      (out_item_o.target_width == '0) && (out_item_o.target_height == '0) &&
      (out_item_o.target_score == '0))
    else $error("result without target has nonzero fields");

  // the squared gate follows a radius write through the radius register and then the square register
  a_gate_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && (cfg_index_i == CfgGateRadius)) |=>
      ##1 (gate_sq_q == GateSqW'(GateSqW'($past(cfg_data_i, 2)) *
                                 GateSqW'($past(cfg_data_i, 2)))))
    else $error("squared gate out of step with radius");
`endif

endmodule
